// ===== sv/mer_pkg.sv =====
// Package for the midpoint ellipse rasterizer: command and result types,
// datapath widths and default sizes. No dependencies.
package mer_pkg;

	// Default configuration
	localparam int MAX_RADIUS_DEF = 31;
	localparam int CMD_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF  = 2;

	// Results per command never exceed this count
	localparam int RESULT_CAP = 64;

	// Multiplier operand, product and decision widths
	localparam int MW = 12;
	localparam int PW = 24;
	localparam int DW = 28;

	typedef struct packed {
		logic              fill;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic        [4:0]  rx;
		logic        [4:0]  ry;
		logic        [15:0] colour;
	} cmd_t;

	typedef struct packed {
		logic [15:0] right_x;
		logic [15:0] left_x;
		logic [15:0] top_y;
		logic [15:0] bottom_y;
		logic [5:0]  span_len;
		logic [15:0] colour;
		logic        last;
	} res_t;

endpackage

// ===== sv/mer_fifo.sv =====
// Small first-in first-out queue with a full/empty handshake.
// Depends on nothing; used for the command queue and the result queue.
module mer_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mer_front.sv =====
// Command front end: takes ellipse commands, limits the radii and queues them.
// Depends on mer_pkg and mer_fifo.
module mer_front
	import mer_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [4:0]  radius_x,
	input  logic [4:0]  radius_y,
	input  logic [15:0] colour,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);
	cmd_t                  cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_bits;
	logic                  cmd_empty;

	// Saturate radii and pack the command
	always_comb begin
		cmd_in.fill   = func;
		cmd_in.cx     = origin_x;
		cmd_in.cy     = origin_y;
		cmd_in.rx     = (radius_x > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius_x;
		cmd_in.ry     = (radius_y > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : radius_y;
		cmd_in.colour = colour;
	end

	mer_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_bits),
		.empty   (cmd_empty)
	);

	assign cmd       = cmd_t'(cmd_bits);
	assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/mer_engine.sv =====
// Ellipse step engine: sets up decision terms with one shared multiplier and
// walks both regions, one result per cycle unless res_full. Needs mer_pkg.
module mer_engine
	import mer_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res,
	input  logic res_full
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ_RX = 4'd1;
	localparam logic [3:0] ST_SQ_RY = 4'd2;
	localparam logic [3:0] ST_MUL_T = 4'd3;
	localparam logic [3:0] ST_INIT  = 4'd4;
	localparam logic [3:0] ST_R1    = 4'd5;
	localparam logic [3:0] ST_R2_A  = 4'd6;
	localparam logic [3:0] ST_R2_B  = 4'd7;
	localparam logic [3:0] ST_R2_C  = 4'd8;
	localparam logic [3:0] ST_R2_D  = 4'd9;
	localparam logic [3:0] ST_R2_E  = 4'd10;
	localparam logic [3:0] ST_R2_F  = 4'd11;
	localparam logic [3:0] ST_R2    = 4'd12;

	logic [3:0] state_q, state_d;

	// Held command
	logic        fill_q;
	logic [15:0] cx_q, cy_q, colour_q;
	logic [4:0]  rx_q, ry_q;

	// Setup terms and walk state
	logic [9:0]           rx2_q, ry2_q;
	logic [PW-1:0]        prod_q;
	logic signed [DW-1:0] acc_q, acc_d;
	logic signed [DW-1:0] p_q, p_d;
	logic [6:0]           x_q, x_d;
	logic [5:0]           y_q, y_d;
	logic [17:0]          px_q, px_d;
	logic [16:0]          py_q, py_d;
	logic [6:0]           n_q, n_d;

	// Shared multiplier
	logic          mul_en;
	logic [MW-1:0] mul_a, mul_b;

	// Step helpers
	logic [10:0]          two_rx2, two_ry2;
	logic [17:0]          px_inc;
	logic [16:0]          py_dec, py_r1;
	logic [5:0]           y_dec, ym1;
	logic [6:0]           x_inc, n_inc;
	logic signed [DW-1:0] rx2_e, ry2_e, prod_e, px_inc_e, py_dec_e;
	logic signed [DW-1:0] q1, p_r1_a, p_r1_b, p_r2_a, p_r2_b;
	logic                 out_last;

	function automatic logic signed [DW-1:0] ext(input logic [PW-1:0] v);
		return $signed({{(DW - PW){1'b0}}, v});
	endfunction

	// Divide by four, rounding toward zero
	function automatic logic signed [DW-1:0] trunc4(input logic signed [DW-1:0] q);
		logic signed [DW-1:0] adj;
		adj = (q < 0) ? q + DW'(3) : q;
		return adj >>> 2;
	endfunction

	assign two_rx2  = {rx2_q, 1'b0};
	assign two_ry2  = {ry2_q, 1'b0};
	assign px_inc   = px_q + 18'(two_ry2);
	assign py_dec   = py_q - 17'(two_rx2);
	assign y_dec    = y_q - 6'd1;
	assign x_inc    = x_q + 7'd1;
	assign n_inc    = n_q + 7'd1;
	assign ym1      = (y_q == '0) ? 6'd1 : y_dec;
	assign rx2_e    = ext(PW'(rx2_q));
	assign ry2_e    = ext(PW'(ry2_q));
	assign prod_e   = ext(prod_q);
	assign px_inc_e = ext(PW'(px_inc));
	assign py_dec_e = ext(PW'(py_dec));
	assign q1       = (ry2_e <<< 2) - (prod_e <<< 2) + rx2_e;
	assign p_r1_a   = p_q + ry2_e + px_inc_e;
	assign p_r1_b   = p_r1_a - py_dec_e;
	assign p_r2_a   = p_q + rx2_e - py_dec_e;
	assign p_r2_b   = p_r2_a + px_inc_e;
	assign py_r1    = (p_q < 0) ? py_q : py_dec;

	// Select multiplier operands for each setup cycle
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_SQ_RX: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(rx_q);
			end
			ST_SQ_RY: begin
				mul_a = MW'(ry_q);
				mul_b = MW'(ry_q);
			end
			ST_MUL_T: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry_q);
			end
			ST_R2_A: begin
				mul_a = MW'({x_q, 1'b1});
				mul_b = MW'({x_q, 1'b1});
			end
			ST_R2_B: begin
				mul_a = MW'(ry2_q);
				mul_b = prod_q[MW-1:0];
			end
			ST_R2_C: begin
				mul_a = MW'(ym1);
				mul_b = MW'(ym1);
			end
			ST_R2_D: begin
				mul_a = MW'(rx2_q);
				mul_b = prod_q[MW-1:0];
			end
			ST_R2_E: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry2_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Sequence setup and step both regions
	always_comb begin
		state_d  = state_q;
		x_d      = x_q;
		y_d      = y_q;
		px_d     = px_q;
		py_d     = py_q;
		p_d      = p_q;
		n_d      = n_q;
		acc_d    = acc_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = ST_SQ_RX;
				end
			end
			ST_SQ_RX: state_d = ST_SQ_RY;
			ST_SQ_RY: state_d = ST_MUL_T;
			ST_MUL_T: state_d = ST_INIT;
			ST_INIT: begin
				x_d      = '0;
				y_d      = {1'b0, ry_q};
				px_d     = '0;
				py_d     = {prod_q[15:0], 1'b0};
				p_d      = trunc4(q1);
				n_d      = 7'd1;
				out_last = (ry_q == '0);
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = out_last ? ST_IDLE : ST_R1;
				end
			end
			ST_R1: begin
				if (px_q < py_q) begin
					out_last = (n_inc == 7'(RESULT_CAP))
						|| (!(px_inc < py_r1) && ((p_q < 0) ? (y_q == '0) : (y_dec == '0)));
					if (!res_full) begin
						x_d  = x_inc;
						px_d = px_inc;
						n_d  = n_inc;
						if (p_q < 0) begin
							p_d = p_r1_a;
						end else begin
							y_d  = y_dec;
							py_d = py_dec;
							p_d  = p_r1_b;
						end
						res_push = 1'b1;
						state_d  = out_last ? ST_IDLE : ST_R1;
					end
				end else begin
					state_d = ST_R2_A;
				end
			end
			ST_R2_A: state_d = ST_R2_B;
			ST_R2_B: state_d = ST_R2_C;
			ST_R2_C: begin
				acc_d   = prod_e;
				state_d = ST_R2_D;
			end
			ST_R2_D: state_d = ST_R2_E;
			ST_R2_E: begin
				acc_d   = acc_q + (prod_e <<< 2);
				state_d = ST_R2_F;
			end
			ST_R2_F: begin
				p_d     = trunc4(acc_q - (prod_e <<< 2));
				state_d = ST_R2;
			end
			ST_R2: begin
				if (y_q != '0) begin
					out_last = (y_dec == '0) || (n_inc == 7'(RESULT_CAP));
					if (!res_full) begin
						y_d  = y_dec;
						py_d = py_dec;
						n_d  = n_inc;
						if (p_q > 0) begin
							p_d = p_r2_a;
						end else begin
							x_d  = x_inc;
							px_d = px_inc;
							p_d  = p_r2_b;
						end
						res_push = 1'b1;
						state_d  = out_last ? ST_IDLE : ST_R2;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Form the result transaction from the new offsets
	always_comb begin
		res.right_x  = cx_q + 16'(x_d);
		res.left_x   = cx_q - 16'(x_d);
		res.top_y    = cy_q - 16'(y_d);
		res.bottom_y = cy_q + 16'(y_d);
		res.span_len = fill_q ? {y_d[4:0], 1'b0} : 6'd0;
		res.colour   = colour_q;
		res.last     = out_last;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			fill_q   <= cmd.fill;
			cx_q     <= cmd.cx;
			cy_q     <= cmd.cy;
			rx_q     <= cmd.rx;
			ry_q     <= cmd.ry;
			colour_q <= cmd.colour;
		end
		if (mul_en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (state_q == ST_SQ_RY) begin
			rx2_q <= prod_q[9:0];
		end
		if (state_q == ST_MUL_T) begin
			ry2_q <= prod_q[9:0];
		end
		x_q   <= x_d;
		y_q   <= y_d;
		px_q  <= px_d;
		py_q  <= py_d;
		p_q   <= p_d;
		acc_q <= acc_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

	// The final transaction of a command returns the engine to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.last |=> state_q == ST_IDLE)
		else $error("engine not idle after last result");

	// Region two only runs with rows left to walk
	a_r2_rows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_R2 |-> y_q != '0)
		else $error("region two entered with no rows left");

	// Result count never passes the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> n_q <= 7'(RESULT_CAP))
		else $error("result count above cap");

endmodule

// ===== sv/midpoint_ellipse_rasterizer_unit.sv =====
// Midpoint ellipse rasterizer. A command popped from the command queue goes through three setup
// multiplies and the initial step, which pushes its first result into the result queue.
// Within each region the walk then pushes one result per cycle while the result queue has room,
// with region-two setup multiplies on the one shared multiplier between the regions; the engine
// takes no new command until the last result of the current one is pushed.
// Reset: arst_n asynchronously empties both queues and idles the engine.
module midpoint_ellipse_rasterizer_unit
	import mer_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
	parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [4:0]  radius_x,
	input  logic [4:0]  radius_y,
	input  logic [15:0] colour,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] right_x,
	output logic [15:0] left_x,
	output logic [15:0] top_y,
	output logic [15:0] bottom_y,
	output logic [5:0]  span_len,
	output logic [15:0] pixel_colour,
	output logic        last
);
	logic                    cmd_valid;
	cmd_t                    cmd;
	logic                    cmd_pop;
	logic                    res_push;
	res_t                    res;
	logic                    res_full;
	logic [$bits(res_t)-1:0] head_bits;
	res_t                    head;

	// Accept and queue commands
	mer_front #(
		.MAX_RADIUS (MAX_RADIUS),
		.CMD_DEPTH  (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.radius_x  (radius_x),
		.radius_y  (radius_y),
		.colour    (colour),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Walk the ellipse
	mer_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Hold results until taken
	mer_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (head_bits),
		.empty   (empty)
	);

	assign head         = res_t'(head_bits);
	assign right_x      = head.right_x;
	assign left_x       = head.left_x;
	assign top_y        = head.top_y;
	assign bottom_y     = head.bottom_y;
	assign span_len     = head.span_len;
	assign pixel_colour = head.colour;
	assign last         = head.last;

endmodule

// ===== sim/tb.sv =====
// Testbench for midpoint_ellipse_rasterizer_unit: directed and random ellipse commands,
// predicted per step and checked field by field against every popped result.
// Depends on mer_pkg (cmd_t, res_t, RESULT_CAP) and the rasterizer RTL.
`timescale 1ns / 100ps

module tb
	import mer_pkg::*;
();

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        func = 1'b0;
	logic [15:0] origin_x = '0;
	logic [15:0] origin_y = '0;
	logic [4:0]  radius_x = '0;
	logic [4:0]  radius_y = '0;
	logic [15:0] colour = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] right_x;
	logic [15:0] left_x;
	logic [15:0] top_y;
	logic [15:0] bottom_y;
	logic [5:0]  span_len;
	logic [15:0] pixel_colour;
	logic        last;

	// Steps still to come, oldest first
	res_t pending_steps[$];
	int   error_count = 0;

	// Long receiver hold-off: bump hold_request to start one
	int hold_request = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int pop_mode = 0;
	int mode_left = 0;

	midpoint_ellipse_rasterizer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.colour      (colour),
		.empty       (empty),
		.pop         (pop),
		.right_x     (right_x),
		.left_x      (left_x),
		.top_y       (top_y),
		.bottom_y    (bottom_y),
		.span_len    (span_len),
		.pixel_colour(pixel_colour),
		.last        (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One step of the walk at offsets (x, y) around the command's center
	function automatic res_t pixel_at(cmd_t c, longint x, longint y);
		longint cxl;
		longint cyl;
		res_t   r;
		cxl = $signed(c.cx);
		cyl = $signed(c.cy);
		r.right_x  = 16'(cxl + x);
		r.left_x   = 16'(cxl - x);
		r.top_y    = 16'(cyl - y);
		r.bottom_y = 16'(cyl + y);
		r.span_len = c.fill ? 6'(2 * y) : 6'd0;
		r.colour   = c.colour;
		r.last     = 1'b0;
		return r;
	endfunction

	// Two-region midpoint walk; queue every step the command produces
	function automatic void predict_ellipse(cmd_t c);
		longint rx, ry, rx2, ry2, two_rx2, two_ry2;
		longint x, y, px, py, err, quad;
		res_t   steps[$];
		res_t   tail;
		rx = c.rx;
		ry = c.ry;
		rx2 = rx * rx;
		ry2 = ry * ry;
		two_rx2 = 2 * rx2;
		two_ry2 = 2 * ry2;
		x = 0;
		y = ry;
		px = 0;
		py = two_rx2 * y;
		steps.push_back(pixel_at(c, x, y));

		// region one, start term in quarter units, truncated toward zero
		quad = 4 * ry2 - 4 * rx2 * ry + rx2;
		err = quad / 4;
		while (px < py && steps.size() < RESULT_CAP) begin
			x++;
			px += two_ry2;
			if (err < 0) begin
				err += ry2 + px;
			end else begin
				y--;
				py -= two_rx2;
				err += ry2 + px - py;
			end
			steps.push_back(pixel_at(c, x, y));
		end

		// region two
		quad = ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1)
			- 4 * rx2 * ry2;
		err = quad / 4;
		while (y > 0 && steps.size() < RESULT_CAP) begin
			y--;
			py -= two_rx2;
			if (err > 0) begin
				err += rx2 - py;
			end else begin
				x++;
				px += two_ry2;
				err += rx2 - py + px;
			end
			steps.push_back(pixel_at(c, x, y));
		end

		tail = steps[steps.size() - 1];
		tail.last = 1'b1;
		steps[steps.size() - 1] = tail;
		foreach (steps[i]) pending_steps.push_back(steps[i]);
	endfunction

	function automatic cmd_t make_cmd(logic fill, int cx, int cy, int rx, int ry, int col);
		cmd_t c;
		c.fill   = fill;
		c.cx     = 16'(cx);
		c.cy     = 16'(cy);
		c.rx     = 5'(rx);
		c.ry     = 5'(ry);
		c.colour = 16'(col);
		return c;
	endfunction

	// Radii lean toward the corners now and then
	function automatic int pick_radius();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return $urandom_range(0, 31);
		case (sel)
			7:       return $urandom_range(0, 1);
			8:       return $urandom_range(30, 31);
			default: return 31;
		endcase
	endfunction

	function automatic cmd_t random_ellipse();
		int cx;
		int cy;
		cx = $urandom_range(0, 65535);
		cy = $urandom_range(0, 65535);
		// sometimes park the center next to the wrap points
		if ($urandom_range(0, 4) == 0) cx = 32767 - 40 + $urandom_range(0, 80);
		if ($urandom_range(0, 4) == 0) cy = 32767 - 40 + $urandom_range(0, 80);
		return make_cmd(1'($urandom_range(0, 1)), cx, cy, pick_radius(), pick_radius(),
			$urandom_range(0, 65535));
	endfunction

	// Offer one command and hold it until the block takes it
	task automatic send_ellipse(cmd_t c);
		push     <= 1'b1;
		func     <= c.fill;
		origin_x <= c.cx;
		origin_y <= c.cy;
		radius_x <= c.rx;
		radius_y <= c.ry;
		colour   <= c.colour;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_ellipse(c);
	endtask

	// Drop push and let the sender idle; n sets the pause length (n > 0)
	task automatic idle_sender(int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop push and wait until every predicted step has been popped
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_steps.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] expv, logic [15:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0h, actual %0h", name, expv, actv);
			error_count++;
		end
	endtask

	// Receiver: pop on a changing pattern, check each popped transaction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_steps.size() == 0) begin
				$error("unexpected result: right_x %0h top_y %0h", right_x, top_y);
				error_count++;
			end else begin
				want = pending_steps.pop_front();
				check_field("right_x", want.right_x, right_x);
				check_field("left_x", want.left_x, left_x);
				check_field("top_y", want.top_y, top_y);
				check_field("bottom_y", want.bottom_y, bottom_y);
				check_field("span_len", 16'(want.span_len), 16'(span_len));
				check_field("pixel_colour", want.colour, pixel_colour);
				check_field("last", 16'(want.last), 16'(last));
			end
		end

		if (hold_request != hold_seen) begin
			hold_seen = hold_request;
			hold_left = 400;
		end
		if (mode_left == 0) begin
			pop_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end

		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			case (pop_mode)
				0:       pop <= 1'b1;
				1:       pop <= 1'($urandom_range(0, 1));
				2:       pop <= ($urandom_range(0, 7) == 0);
				default: pop <= mode_left[2];
			endcase
		end
	end

	// Corners of every field, both modes, degenerate radii, coordinate wrap
	task automatic test_directed();
		send_ellipse(make_cmd(1'b0, 0, 0, 0, 0, 'h0000));
		send_ellipse(make_cmd(1'b1, 0, 0, 0, 0, 'hffff));
		send_ellipse(make_cmd(1'b0, 100, -100, 31, 31, 'h1234));
		send_ellipse(make_cmd(1'b1, 100, -100, 31, 31, 'habcd));
		send_ellipse(make_cmd(1'b0, 32767, 32767, 31, 31, 'hffff));
		send_ellipse(make_cmd(1'b1, -32768, -32768, 31, 31, 'h0000));
		send_ellipse(make_cmd(1'b0, 0, 0, 0, 31, 'h5555));
		send_ellipse(make_cmd(1'b1, 0, 0, 0, 31, 'haaaa));
		send_ellipse(make_cmd(1'b0, 0, 0, 31, 0, 'h00ff));
		send_ellipse(make_cmd(1'b1, 0, 0, 31, 0, 'hff00));
		send_ellipse(make_cmd(1'b0, 5, 5, 1, 1, 'h0001));
		send_ellipse(make_cmd(1'b1, 5, 5, 1, 1, 'h8000));
		send_ellipse(make_cmd(1'b0, -1, 1, 31, 1, 'h7fff));
		send_ellipse(make_cmd(1'b1, -1, 1, 1, 31, 'hc3c3));
		send_ellipse(make_cmd(1'b1, 32767, -32768, 30, 2, 'h3c3c));
		send_ellipse(make_cmd(1'b0, -32768, 32767, 2, 30, 'h0f0f));
		send_ellipse(make_cmd(1'b1, 0, 0, 17, 9, 'hf0f0));
		send_ellipse(make_cmd(1'b0, 12, -7, 9, 17, 'h2468));
		wait_drained();
	endtask

	// Receiver holds off while commands keep coming: both queues fill, full rises
	task automatic test_fill_and_stall();
		hold_request++;
		repeat (24) send_ellipse(random_ellipse());
		wait_drained();
	endtask

	// Sender goes quiet until everything is out, then resumes
	task automatic test_sender_pause();
		repeat (3) send_ellipse(random_ellipse());
		wait_drained();
		repeat (3) send_ellipse(random_ellipse());
		wait_drained();
	endtask

	// Random commands in bursts of random length, with random gaps or none between
	task automatic test_random_ellipses();
		int sent;
		int burst;
		int sel;
		sent = 0;
		while (sent < 350) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				send_ellipse(random_ellipse());
				sent++;
			end
			sel = $urandom_range(0, 19);
			if (sel < 10) idle_sender($urandom_range(1, 4));
			else if (sel < 15) idle_sender($urandom_range(5, 40));
			else if (sel == 15) wait_drained();
			// otherwise keep push high into the next burst
		end
		wait_drained();
	endtask

	initial begin
		int drain_cycles;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_fill_and_stall();
		test_sender_pause();
		test_random_ellipses();

		// Drain, then watch a little longer for stray results
		push <= 1'b0;
		drain_cycles = 0;
		while (pending_steps.size() != 0 && drain_cycles < 100000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (pending_steps.size() != 0) begin
			$error("%0d expected results never arrived", pending_steps.size());
			error_count++;
		end
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
